// ===== rtl/core/pose_point_transform_core_macros.svh =====
// Assertion macros shared by the pose point transform RTL.
// Expects clk and arst_n in the scope of the including module.
`ifndef POSE_POINT_TRANSFORM_CORE_MACROS_SVH
`define POSE_POINT_TRANSFORM_CORE_MACROS_SVH

// same-cycle implication
`define PPTC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define PPTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== rtl/core/pptc_pkg.sv =====
// Package for the pose point transform core: widths, constants, types,
// CORDIC arctangent table and coefficient helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pptc_pkg;

	localparam int COORD_W    = 32;
	localparam int ANGLE_W    = 16;
	localparam int COEF_FRAC  = 29;
	localparam int COEF_W     = COEF_FRAC + 2;
	localparam int ACC_W      = 64;
	localparam int Z_W        = 35;
	localparam int XY_W       = 34;
	localparam int MUL_W      = 2 * XY_W;
	localparam int Q_W        = 36;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [4:0] CORDIC_LAST = 5'd23;
	localparam logic [3:0] MAT_LAST    = 4'd14;

	localparam logic signed [Z_W-1:0] Q30_PI      = 35'sd3373259426;
	localparam logic signed [Z_W-1:0] Q30_HALF_PI = 35'sd1686629713;
	localparam logic signed [Z_W-1:0] Q30_TWO_PI  = 35'sd6746518852;
	localparam logic signed [XY_W-1:0] CORDIC_K   = 34'sh026DD3B6A;

	// sine/cosine store slots
	localparam logic [2:0] V_SR   = 3'd0;
	localparam logic [2:0] V_CR   = 3'd1;
	localparam logic [2:0] V_SP   = 3'd2;
	localparam logic [2:0] V_CP   = 3'd3;
	localparam logic [2:0] V_SY   = 3'd4;
	localparam logic [2:0] V_CY   = 3'd5;
	localparam logic [2:0] V_SRSP = 3'd6;
	localparam logic [2:0] V_CRSP = 3'd7;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRANS_X   = 4'd0,
		REG_TRANS_Y   = 4'd1,
		REG_TRANS_Z   = 4'd2,
		REG_ROLL      = 4'd3,
		REG_PITCH     = 4'd4,
		REG_YAW       = 4'd5,
		REG_ROT_ONLY  = 4'd6,
		REG_DIRECTION = 4'd7
	} cfg_reg_t;

	// coordinate 0 (x) in the lowest bits
	typedef logic [2:0][COORD_W-1:0] point_t;

	typedef struct packed {
		logic [2:0][2:0][COEF_W-1:0] w;
		logic [2:0][ACC_W-1:0]       off;
	} pose_t;

	typedef struct packed {
		logic [2:0] a;
		logic [2:0] b;
		logic       to_v;
		logic [3:0] dst;
		logic       first;
		logic       neg;
		logic       live;
	} mat_op_t;

	function automatic mat_op_t mk_op(input logic [2:0] a, input logic [2:0] b,
			input logic to_v, input logic [3:0] dst, input logic first, input logic neg);
		mat_op_t r;
		r.a     = a;
		r.b     = b;
		r.to_v  = to_v;
		r.dst   = dst;
		r.first = first;
		r.neg   = neg;
		r.live  = 1'b1;
		return r;
	endfunction

	// product schedule for the rotation matrix, q index = 3*row + col
	function automatic mat_op_t mat_op(input logic [3:0] st);
		mat_op_t r;
		case (st)
			4'd0:    r = mk_op(V_SR,   V_SP, 1'b1, 4'd6, 1'b0, 1'b0);
			4'd1:    r = mk_op(V_CR,   V_SP, 1'b1, 4'd7, 1'b0, 1'b0);
			4'd2:    r = mk_op(V_CP,   V_CY, 1'b0, 4'd0, 1'b1, 1'b0);
			4'd3:    r = mk_op(V_CP,   V_SY, 1'b0, 4'd1, 1'b1, 1'b1);
			4'd4:    r = mk_op(V_CR,   V_SY, 1'b0, 4'd3, 1'b1, 1'b0);
			4'd5:    r = mk_op(V_SRSP, V_CY, 1'b0, 4'd3, 1'b0, 1'b0);
			4'd6:    r = mk_op(V_CR,   V_CY, 1'b0, 4'd4, 1'b1, 1'b0);
			4'd7:    r = mk_op(V_SRSP, V_SY, 1'b0, 4'd4, 1'b0, 1'b1);
			4'd8:    r = mk_op(V_CP,   V_SR, 1'b0, 4'd5, 1'b1, 1'b1);
			4'd9:    r = mk_op(V_SR,   V_SY, 1'b0, 4'd6, 1'b1, 1'b0);
			4'd10:   r = mk_op(V_CRSP, V_CY, 1'b0, 4'd6, 1'b0, 1'b1);
			4'd11:   r = mk_op(V_SR,   V_CY, 1'b0, 4'd7, 1'b1, 1'b0);
			4'd12:   r = mk_op(V_CRSP, V_SY, 1'b0, 4'd7, 1'b0, 1'b0);
			4'd13:   r = mk_op(V_CR,   V_CP, 1'b0, 4'd8, 1'b1, 1'b0);
			default: begin
				r = mk_op(V_SP, V_SP, 1'b0, 4'd0, 1'b0, 1'b0);
				r.live = 1'b0;
			end
		endcase
		return r;
	endfunction

	function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] i);
		logic signed [Z_W-1:0] r;
		case (i)
			5'd0:    r = 35'sh03243F6A8;
			5'd1:    r = 35'sh01DAC6705;
			5'd2:    r = 35'sh00FADBAFC;
			5'd3:    r = 35'sh007F56EA6;
			5'd4:    r = 35'sh003FEAB76;
			5'd5:    r = 35'sh001FFD55B;
			5'd6:    r = 35'sh000FFFAAA;
			5'd7:    r = 35'sh0007FFF55;
			5'd8:    r = 35'sh0003FFFEA;
			5'd9:    r = 35'sh0001FFFFD;
			5'd10:   r = 35'sh0000FFFFF;
			5'd11:   r = 35'sh00007FFFF;
			5'd12:   r = 35'sh00003FFFF;
			5'd13:   r = 35'sh00001FFFF;
			5'd14:   r = 35'sh00000FFFF;
			5'd15:   r = 35'sh000007FFF;
			5'd16:   r = 35'sh000003FFF;
			5'd17:   r = 35'sh000001FFF;
			5'd18:   r = 35'sh000000FFF;
			5'd19:   r = 35'sh0000007FF;
			5'd20:   r = 35'sh0000003FF;
			5'd21:   r = 35'sh0000001FF;
			5'd22:   r = 35'sh0000000FF;
			5'd23:   r = 35'sh00000007F;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Q30 to Q29 with round half up, clamped to +-1.0
	function automatic logic signed [COEF_W-1:0] to_coef(input logic signed [Q_W-1:0] q);
		logic signed [Q_W-1:0] r;
		logic signed [Q_W-1:0] lim;
		lim = $signed(Q_W'(1)) <<< COEF_FRAC;
		r = (q + $signed(Q_W'(1))) >>> 1;
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r[COEF_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pptc_fifo.sv =====
// Front queue of the pose point transform core: accepted points wait here.
// Depends on pptc_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "pose_point_transform_core_macros.svh"
module pptc_fifo import pptc_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire point_t din,
	input  wire logic   pop,
	output point_t      dout,
	output logic        empty,
	output logic        full
);

	point_t           mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(FIFO_DEPTH));
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + PTR_W'(1);
			if (pop)
				rd_q <= rd_q + PTR_W'(1);
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	`PPTC_ASSERT_NEXT(a_fifo_count, 1'b1, count_q == $past(count_q) + CNT_W'($past(push)) - CNT_W'($past(pop)), "fifo count out of step")

endmodule
`default_nettype wire

// ===== rtl/core/pptc_coef.sv =====
// Pose engine: configuration registers, iterative CORDIC sine/cosine,
// sequenced matrix and offset products on one shared multiplier. Uses pptc_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "pose_point_transform_core_macros.svh"
module pptc_coef import pptc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output pose_t                      pose,
	output logic                       ready
);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_PREP   = 8'b0000_0010,
		ST_ROT    = 8'b0000_0100,
		ST_SAVE_S = 8'b0000_1000,
		ST_SAVE_C = 8'b0001_0000,
		ST_MAT    = 8'b0010_0000,
		ST_COEF   = 8'b0100_0000,
		ST_OFS    = 8'b1000_0000
	} state_t;

	localparam logic signed [MUL_W-1:0] RND30 = MUL_W'(1) << 29;

	logic [2:0][COORD_W-1:0] trans_q;
	logic [2:0][ANGLE_W-1:0] ang_q;
	logic                    rot_only_q;
	logic                    dir_q;
	logic                    dirty_q;

	state_t                  state_q;
	logic [1:0]              sel_q;
	logic [4:0]              it_q;
	logic [3:0]              st_q;
	logic [1:0]              oi_q;
	logic [1:0]              oj_q;
	logic signed [XY_W-1:0]  x_q;
	logic signed [XY_W-1:0]  y_q;
	logic signed [Z_W-1:0]   z_q;
	logic                    neg_q;

	logic signed [XY_W-1:0]  v_mem [8];
	logic signed [XY_W-1:0]  rd_a_q;
	logic signed [XY_W-1:0]  rd_b_q;
	mat_op_t                 op1_q;
	mat_op_t                 op2_q;
	logic                    ofs1_q;
	logic                    ofs2_q;
	logic [1:0]              ax1_q;
	logic [1:0]              ax2_q;
	logic                    v1_q;
	logic                    v2_q;
	logic signed [MUL_W-1:0] prod_q;

	logic signed [Q_W-1:0]        q_q [9];
	logic [2:0][2:0][COEF_W-1:0]  w_q;
	logic [2:0][ACC_W-1:0]        off_q;

	logic [2:0][COORD_W-1:0] te;
	mat_op_t                 op;
	logic                    issue;
	logic signed [Z_W-1:0]   z0;
	logic signed [Z_W-1:0]   z1;
	logic signed [Z_W-1:0]   z2;
	logic                    neg2;
	logic signed [XY_W-1:0]  dx;
	logic signed [XY_W-1:0]  dy;
	logic signed [MUL_W-1:0] rnd;
	logic signed [Q_W-1:0]   r36;
	logic                    v_we;
	logic [2:0]              v_wa;
	logic signed [XY_W-1:0]  v_wd;

	assign te    = rot_only_q ? '0 : trans_q;
	assign op    = mat_op(st_q);
	assign issue = ((state_q == ST_MAT) && op.live) || ((state_q == ST_OFS) && (oi_q != 2'd3));
	assign ready = (state_q == ST_IDLE) && !dirty_q;
	assign pose.w   = w_q;
	assign pose.off = off_q;

	always_comb begin
		z0 = {{(Z_W-ANGLE_W){ang_q[sel_q][ANGLE_W-1]}}, ang_q[sel_q]} <<< (33 - ANGLE_W);
		if (z0 > Q30_PI)
			z1 = z0 - Q30_TWO_PI;
		else if (z0 < -Q30_PI)
			z1 = z0 + Q30_TWO_PI;
		else
			z1 = z0;
		neg2 = 1'b1;
		if (z1 > Q30_HALF_PI)
			z2 = z1 - Q30_PI;
		else if (z1 < -Q30_HALF_PI)
			z2 = z1 + Q30_PI;
		else begin
			z2   = z1;
			neg2 = 1'b0;
		end
	end

	assign dx  = y_q >>> it_q;
	assign dy  = x_q >>> it_q;
	assign rnd = (prod_q + RND30) >>> 30;
	assign r36 = rnd[Q_W-1:0];

	always_comb begin
		v_we = 1'b0;
		v_wa = op2_q.dst[2:0];
		v_wd = r36[XY_W-1:0];
		if (state_q == ST_SAVE_S) begin
			v_we = 1'b1;
			v_wa = {sel_q, 1'b0};
			v_wd = neg_q ? -y_q : y_q;
		end else if (state_q == ST_SAVE_C) begin
			v_we = 1'b1;
			v_wa = {sel_q, 1'b1};
			v_wd = neg_q ? -x_q : x_q;
		end else if (v2_q && !ofs2_q && op2_q.to_v) begin
			v_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trans_q    <= '0;
			ang_q      <= '0;
			rot_only_q <= 1'b0;
			dir_q      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_TRANS_X:   trans_q[0] <= cfg_wdata[COORD_W-1:0];
				REG_TRANS_Y:   trans_q[1] <= cfg_wdata[COORD_W-1:0];
				REG_TRANS_Z:   trans_q[2] <= cfg_wdata[COORD_W-1:0];
				REG_ROLL:      ang_q[0]   <= cfg_wdata[ANGLE_W-1:0];
				REG_PITCH:     ang_q[1]   <= cfg_wdata[ANGLE_W-1:0];
				REG_YAW:       ang_q[2]   <= cfg_wdata[ANGLE_W-1:0];
				REG_ROT_ONLY:  rot_only_q <= cfg_wdata[0];
				REG_DIRECTION: dir_q      <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dirty_q <= 1'b1;
			sel_q   <= '0;
			it_q    <= '0;
			st_q    <= '0;
			oi_q    <= '0;
			oj_q    <= '0;
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
		end else begin
			if (cfg_we)
				dirty_q <= 1'b1;
			else if ((state_q == ST_IDLE) && dirty_q)
				dirty_q <= 1'b0;
			v1_q <= issue;
			v2_q <= v1_q;
			case (state_q)
				ST_IDLE: begin
					if (dirty_q) begin
						state_q <= ST_PREP;
						sel_q   <= '0;
					end
				end
				ST_PREP: begin
					state_q <= ST_ROT;
					it_q    <= '0;
				end
				ST_ROT: begin
					if (it_q == CORDIC_LAST)
						state_q <= ST_SAVE_S;
					else
						it_q <= it_q + 5'd1;
				end
				ST_SAVE_S: state_q <= ST_SAVE_C;
				ST_SAVE_C: begin
					if (sel_q == 2'd2) begin
						state_q <= ST_MAT;
						st_q    <= '0;
					end else begin
						state_q <= ST_PREP;
						sel_q   <= sel_q + 2'd1;
					end
				end
				ST_MAT: begin
					if (st_q != MAT_LAST)
						st_q <= st_q + 4'd1;
					else if (!v1_q && !v2_q)
						state_q <= ST_COEF;
				end
				ST_COEF: begin
					oi_q <= '0;
					oj_q <= '0;
					state_q <= (dir_q && !rot_only_q) ? ST_OFS : ST_IDLE;
				end
				ST_OFS: begin
					if (oi_q != 2'd3) begin
						if (oj_q == 2'd2) begin
							oj_q <= '0;
							oi_q <= oi_q + 2'd1;
						end else begin
							oj_q <= oj_q + 2'd1;
						end
					end else if (!v1_q && !v2_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PREP) begin
			x_q   <= CORDIC_K;
			y_q   <= '0;
			z_q   <= z2;
			neg_q <= neg2;
		end else if (state_q == ST_ROT) begin
			if (z_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_q30(it_q);
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_q30(it_q);
			end
		end
		if (v_we)
			v_mem[v_wa] <= v_wd;
		if (state_q == ST_OFS) begin
			rd_a_q <= XY_W'($signed(w_q[oi_q][oj_q]));
			rd_b_q <= XY_W'($signed(te[oj_q]));
		end else begin
			rd_a_q <= v_mem[op.a];
			rd_b_q <= v_mem[op.b];
		end
		op1_q  <= op;
		ofs1_q <= (state_q == ST_OFS);
		ax1_q  <= oi_q;
		prod_q <= MUL_W'(rd_a_q) * MUL_W'(rd_b_q);
		op2_q  <= op1_q;
		ofs2_q <= ofs1_q;
		ax2_q  <= ax1_q;
		if (v2_q && !ofs2_q && !op2_q.to_v)
			q_q[op2_q.dst] <= (op2_q.first ? '0 : q_q[op2_q.dst]) + (op2_q.neg ? -r36 : r36);
		if (state_q == ST_COEF) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					if (dir_q)
						w_q[j][i] <= (i == 0 && j == 2) ? to_coef(Q_W'(rd_a_q))
							: to_coef(q_q[3*i+j]);
					else
						w_q[i][j] <= (i == 0 && j == 2) ? to_coef(Q_W'(rd_a_q))
							: to_coef(q_q[3*i+j]);
				end
				off_q[i] <= (dir_q || rot_only_q) ? '0
					: ACC_W'($signed(trans_q[i])) <<< COEF_FRAC;
			end
		end else if (v2_q && ofs2_q) begin
			off_q[ax2_q] <= off_q[ax2_q] - prod_q[ACC_W-1:0];
		end
	end

	`PPTC_ASSERT_NOW(a_ready_drained, ready, !v1_q && !v2_q, "pose ready with products in flight")
	`PPTC_ASSERT_NEXT(a_prep_to_rot, state_q == ST_PREP, state_q == ST_ROT, "CORDIC did not start after prep")

endmodule
`default_nettype wire

// ===== rtl/core/pptc_dp.sv =====
// Back end of the pose point transform core: four-stage multiply, sum,
// round and saturate pipeline with the output register. Uses pptc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pptc_dp import pptc_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire point_t pt,
	input  wire logic   pt_valid,
	output logic        pop,
	input  wire pose_t  pose,
	output logic        out_valid,
	input  wire logic   out_ready,
	output point_t      out_pt,
	output logic        out_sat
);

	localparam logic signed [ACC_W-1:0] RND29   = ACC_W'(1) << (COEF_FRAC - 1);
	localparam logic signed [ACC_W-1:0] SAT_MAX = (ACC_W'(1) << (COORD_W - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] SAT_MIN = -(ACC_W'(1) << (COORD_W - 1));

	logic signed [ACC_W-1:0] pr_s1  [3][3];
	logic signed [ACC_W-1:0] a_s2   [3];
	logic signed [ACC_W-1:0] b_s2   [3];
	logic signed [ACC_W-1:0] acc_s3 [3];
	point_t                  out_s4;
	logic                    sat_s4;
	logic                    v_s1, v_s2, v_s3, v_s4;
	logic                    en;
	logic signed [ACC_W-1:0] rr [3];
	logic [2:0]              sat_ax;
	point_t                  res;

	assign en        = !v_s4 || out_ready;
	assign pop       = pt_valid && en;
	assign out_valid = v_s4;
	assign out_pt    = out_s4;
	assign out_sat   = sat_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rr[i] = (acc_s3[i] + RND29) >>> COEF_FRAC;
			sat_ax[i] = 1'b1;
			if (rr[i] > SAT_MAX)
				res[i] = SAT_MAX[COORD_W-1:0];
			else if (rr[i] < SAT_MIN)
				res[i] = SAT_MIN[COORD_W-1:0];
			else begin
				res[i] = rr[i][COORD_W-1:0];
				sat_ax[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++)
					pr_s1[i][j] <= ACC_W'($signed(pose.w[i][j])) * ACC_W'($signed(pt[j]));
				a_s2[i]   <= pr_s1[i][0] + pr_s1[i][1];
				b_s2[i]   <= pr_s1[i][2] + $signed(pose.off[i]);
				acc_s3[i] <= a_s2[i] + b_s2[i];
			end
			out_s4 <= res;
			sat_s4 <= |sat_ax;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/pose_point_transform_core.sv =====
// Top level of the pose point transform core: point queue, pose engine and
// transform pipeline. Uses pptc_pkg, pptc_fifo, pptc_coef and pptc_dp.
//
//  channel | dir | fields (lowest bits first)
//  s_*     | in  | tdata: point_x, point_y, point_z
//  m_*     | out | tdata: out_x, out_y, out_z; tuser: saturated_flag
//  cfg_*   | in  | register index, write data (no read-back)
//
// One point per cycle sustained while m_tready is high and the pose is ready.
// After reset and after any register write the pose engine rebuilds the
// matrix (three 24-step CORDIC runs, 14 products, 9 offset products in
// world-to-robot mode when not rotation-only) with s_tready low.
// A stalled m_tready holds the pipeline; the four-entry queue accepts until full.
`timescale 1ns / 1ps
`default_nettype none
module pose_point_transform_core import pptc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [3*COORD_W-1:0]  s_tdata,   // point_x, point_y, point_z
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [3*COORD_W-1:0]       m_tdata,   // out_x, out_y, out_z
	output logic [0:0]                 m_tuser,   // saturated_flag
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	pose_t  pose;
	logic   pose_ready;
	logic   push;
	logic   pop;
	logic   empty;
	logic   full;
	point_t head;
	point_t res;
	logic   sat;

	assign s_tready = !full && pose_ready;
	assign push     = s_tvalid && s_tready;
	assign m_tdata  = res;
	assign m_tuser  = sat;

	pptc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (s_tdata),
		.pop    (pop),
		.dout   (head),
		.empty  (empty),
		.full   (full)
	);

	pptc_coef u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pose      (pose),
		.ready     (pose_ready)
	);

	pptc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt        (head),
		.pt_valid  (!empty),
		.pop       (pop),
		.pose      (pose),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pt    (res),
		.out_sat   (sat)
	);

endmodule
`default_nettype wire
